// ----- rtl/sps_pkg.sv -----
// Shared constants, types and coil pattern tables for the stepper phase sequencer.
package sps_pkg;

    // Width of the move length counter (saturation point is 2^COUNT_BITS-1).
    localparam int COUNT_BITS = 16;

    localparam int AMOUNT_W   = 16;
    localparam int SPR_W      = 13;
    localparam int TPP_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CMD_W      = 2;
    localparam int COIL_W     = 4;

    // Degrees in one rotation; angle moves divide by this.
    localparam int ANGLE_DIV = 360;
    localparam int DIV_W     = $clog2(ANGLE_DIV);

    // Raw product amount * steps_per_rev.
    localparam int PROD_W = AMOUNT_W + SPR_W;

    // Remaining-count register: holds the saturated product, in degree units
    // for angle moves and in cycles for rotation moves.
    localparam int REM_W = (PROD_W < COUNT_BITS + DIV_W) ? PROD_W : COUNT_BITS + DIV_W;

    // Largest product that still maps to a count within range.
    localparam logic [63:0] SAT_ANGLE =
        ((64'(1) << COUNT_BITS) * 64'(ANGLE_DIV)) - 64'(1);
    localparam logic [63:0] SAT_ROT = (64'(1) << COUNT_BITS) - 64'(1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ANGLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_STEPS_PER_REV     = 1'b0;
    localparam logic CFG_TICKS_PER_PATTERN = 1'b1;

    localparam logic [SPR_W-1:0] SPR_RESET = 13'd512;
    localparam logic [TPP_W-1:0] TPP_RESET = 16'd2;

    // Counter-clockwise order; clockwise walks the table backwards.
    localparam logic [COIL_W-1:0] WAVE_CCW [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [COIL_W-1:0] HALF_CCW [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    // Item after the input register: decoded command plus the precomputed product.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              ccw;
        logic              half;
        logic [PROD_W-1:0] product;
    } sps_item_t;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              busy;
        logic              done;
    } sps_result_t;

    function automatic logic [COIL_W-1:0] pattern_at(input logic [2:0] idx,
                                                     input logic       half,
                                                     input logic       ccw);
        logic [2:0] hi;
        logic [1:0] wi;
        hi = ccw ? idx : (3'd7 - idx);
        wi = ccw ? idx[1:0] : (2'd3 - idx[1:0]);
        if (half)
            return HALF_CCW[hi];
        else
            return WAVE_CCW[wi];
    endfunction

endpackage

// ----- rtl/sps_if.sv -----
// Valid/ready channel interfaces for the command input and the coil result output.
interface sps_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [sps_pkg::CMD_W-1:0]      command;
    logic [sps_pkg::AMOUNT_W-1:0]   amount;
    logic                           counter_clockwise;
    logic                           half_step;

    modport source (
        output valid, command, amount, counter_clockwise, half_step,
        input  ready
    );
    modport sink (
        input  valid, command, amount, counter_clockwise, half_step,
        output ready
    );
endinterface

interface sps_res_if;
    logic                           valid;
    logic                           ready;
    logic [sps_pkg::COIL_W-1:0]     coils;
    logic                           busy_res;
    logic                           done_res;

    modport source (
        output valid, coils, busy_res, done_res,
        input  ready
    );
    modport sink (
        input  valid, coils, busy_res, done_res,
        output ready
    );
endinterface

// ----- rtl/sps_core.sv -----
// Move state, pattern stepping and move-length counting for the stepper sequencer.
module sps_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  sps_pkg::sps_item_t            item,
    input  logic [sps_pkg::TPP_W-1:0]     tpp,
    output sps_pkg::sps_result_t          result
);

    logic                              moving_reg, moving_next;
    logic                              dir_reg, dir_next;
    logic                              half_reg, half_next;
    logic                              angle_reg, angle_next;
    logic [sps_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [2:0]                        pidx_reg, pidx_next;
    logic [sps_pkg::TPP_W-1:0]         hold_reg, hold_next;
    logic [sps_pkg::COIL_W-1:0]        coil_reg, coil_next;

    logic                              done;
    logic [sps_pkg::TPP_W-1:0]         hold_w;
    logic [sps_pkg::TPP_W:0]           hold_inc;
    logic [2:0]                        last_idx;
    logic [sps_pkg::REM_W-1:0]         rem_dec;
    logic                              cycle_end;
    logic                              angle_cmd;
    logic                              start_ok;
    logic [63:0]                       sat;
    logic [sps_pkg::REM_W-1:0]         rem_init;

    always_comb
    begin
        moving_next = moving_reg;
        dir_next    = dir_reg;
        half_next   = half_reg;
        angle_next  = angle_reg;
        rem_next    = rem_reg;
        pidx_next   = pidx_reg;
        hold_next   = hold_reg;
        coil_next   = coil_reg;
        done        = 1'b0;

        // A zero hold setting behaves as one tick.
        hold_w   = (tpp == '0) ? sps_pkg::TPP_W'(1) : tpp;
        hold_inc = {1'b0, hold_reg} + (sps_pkg::TPP_W + 1)'(1);
        last_idx = half_reg ? 3'd7 : 3'd3;

        // Angle moves count down in degree units, rotation moves in cycles.
        rem_dec   = rem_reg - (angle_reg ? sps_pkg::REM_W'(sps_pkg::ANGLE_DIV)
                                         : sps_pkg::REM_W'(1));
        cycle_end = angle_reg ? (rem_dec < sps_pkg::REM_W'(sps_pkg::ANGLE_DIV))
                              : (rem_dec == '0);

        angle_cmd = (item.command == sps_pkg::CMD_ANGLE);
        start_ok  = angle_cmd ? (item.product >= sps_pkg::PROD_W'(sps_pkg::ANGLE_DIV))
                              : (item.product != '0);
        sat       = angle_cmd ? sps_pkg::SAT_ANGLE : sps_pkg::SAT_ROT;
        rem_init  = (64'(item.product) > sat) ? sps_pkg::REM_W'(sat)
                                              : sps_pkg::REM_W'(item.product);

        if (step_en)
        begin
            case (item.command)
                sps_pkg::CMD_TICK:
                begin
                    if (moving_reg)
                    begin
                        hold_next = hold_reg + sps_pkg::TPP_W'(1);
                        if (hold_inc >= {1'b0, hold_w})
                        begin
                            hold_next = '0;
                            if (pidx_reg >= last_idx)
                            begin
                                pidx_next = '0;
                                rem_next  = rem_dec;
                                if (cycle_end)
                                begin
                                    moving_next = 1'b0;
                                    done        = 1'b1;
                                end
                                else
                                begin
                                    coil_next = sps_pkg::pattern_at(3'd0, half_reg, dir_reg);
                                end
                            end
                            else
                            begin
                                pidx_next = pidx_reg + 3'd1;
                                coil_next = sps_pkg::pattern_at(pidx_reg + 3'd1,
                                                                half_reg, dir_reg);
                            end
                        end
                    end
                end
                sps_pkg::CMD_ANGLE, sps_pkg::CMD_ROTATE:
                begin
                    if (!moving_reg && start_ok)
                    begin
                        moving_next = 1'b1;
                        dir_next    = item.ccw;
                        half_next   = item.half;
                        angle_next  = angle_cmd;
                        rem_next    = rem_init;
                        pidx_next   = '0;
                        hold_next   = '0;
                        coil_next   = sps_pkg::pattern_at(3'd0, item.half, item.ccw);
                    end
                end
                default:
                begin
                end
            endcase
        end

        result = '{coils: coil_next, busy: moving_next, done: done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg <= 1'b0;
            dir_reg    <= 1'b0;
            half_reg   <= 1'b0;
            angle_reg  <= 1'b0;
            rem_reg    <= '0;
            pidx_reg   <= '0;
            hold_reg   <= '0;
            coil_reg   <= '0;
        end
        else
        begin
            moving_reg <= moving_next;
            dir_reg    <= dir_next;
            half_reg   <= half_next;
            angle_reg  <= angle_next;
            rem_reg    <= rem_next;
            pidx_reg   <= pidx_next;
            hold_reg   <= hold_next;
            coil_reg   <= coil_next;
        end
    end

    // Idle always leaves the hold counter cleared.
    a_idle_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !moving_reg |-> hold_reg == '0)
        else $error("hold counter nonzero while idle");

    // A running move always has count left and a pattern on the coils.
    a_moving_count: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (rem_reg != '0) && (coil_reg != '0))
        else $error("move running with empty count or dark coils");

    // Wave drive never steps past the fourth pattern.
    a_wave_index: assert property (@(posedge clk) disable iff (!rst_n)
        (moving_reg && !half_reg) |-> pidx_reg <= 3'd3)
        else $error("wave pattern index out of range");

    // Ending a move keeps the last pattern on the coils.
    a_end_keeps_coils: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(moving_reg) |-> $stable(coil_reg))
        else $error("coils changed when move ended");

endmodule

// ----- rtl/stepper_phase_sequencer_top.sv -----
// Top level of the stepper phase sequencer: handshake, config registers, input and result stages.
// A result passes the input register and then the result register before it is offered.
// Throughput: one command per cycle while the result output is not stalled; the move-length
//   multiply sits before the input register, the state update between input and result registers.
// Reset (rst_n low, asynchronous): motor idle, coils off, steps_per_rev 512,
//   ticks_per_pattern 2, both pipeline stages empty.
// Output stalls hold the whole pipeline; no transfer is dropped or repeated.
module stepper_phase_sequencer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]      cfg_data,
    sps_cmd_if.sink                             cmd,
    sps_res_if.source                           res
);

    logic [sps_pkg::SPR_W-1:0]   spr_reg;
    logic [sps_pkg::TPP_W-1:0]   tpp_reg;

    logic                        s1_valid_reg;
    sps_pkg::sps_item_t          s1_item_reg;
    sps_pkg::sps_item_t          s1_item_next;

    logic                        res_valid_reg;
    sps_pkg::sps_result_t        res_reg;
    sps_pkg::sps_result_t        core_result;

    logic                        advance;

    // Advance both stages whenever the result slot is free or being drained this cycle.
    assign advance   = !res_valid_reg || res.ready;
    assign cmd.ready = advance;

    // Form the raw move length on the way into the input register; the core only
    // compares and saturates it.
    always_comb
    begin
        s1_item_next.command = cmd.command;
        s1_item_next.ccw     = cmd.counter_clockwise;
        s1_item_next.half    = cmd.half_step;
        s1_item_next.product = sps_pkg::PROD_W'(cmd.amount) * sps_pkg::PROD_W'(spr_reg);
    end

    // Config registers and stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg       <= sps_pkg::SPR_RESET;
            tpp_reg       <= sps_pkg::TPP_RESET;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sps_pkg::CFG_STEPS_PER_REV:     spr_reg <= cfg_data[sps_pkg::SPR_W-1:0];
                    sps_pkg::CFG_TICKS_PER_PATTERN: tpp_reg <= cfg_data[sps_pkg::TPP_W-1:0];
                    default:                        spr_reg <= spr_reg;
                endcase
            end
            if (advance)
            begin
                s1_valid_reg  <= cmd.valid;
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload stages: capture on transfer, hold while stalled.
    always_ff @(posedge clk)
    begin
        if (advance && cmd.valid)
            s1_item_reg <= s1_item_next;
        if (advance && s1_valid_reg)
            res_reg <= core_result;
    end

    // Move state lives in the core; it updates once per item leaving the input stage.
    sps_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance && s1_valid_reg),
        .item    (s1_item_reg),
        .tpp     (tpp_reg),
        .result  (core_result)
    );

    assign res.valid    = res_valid_reg;
    assign res.coils    = res_reg.coils;
    assign res.busy_res = res_reg.busy;
    assign res.done_res = res_reg.done;

endmodule
